@@ rtl/quadratic_point_warp_2d_macros.svh @@
// Assertion helpers shared by the warp RTL.
`ifndef QUADRATIC_POINT_WARP_2D_MACROS_SVH
`define QUADRATIC_POINT_WARP_2D_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define QPW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define QPW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/qpw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package qpw_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int COEF_WIDTH_DEF  = 32;

    localparam int OUT_W      = 32;
    localparam int HALF_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_DISP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAD_U  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRAD_V  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CURV_1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CURV_2  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CURV_3  = 3'd5;

    // accumulator LSB is 2^-49
    localparam int ONE_Q28   = 1 << 28;
    localparam int LIN_SHIFT = 17;
    localparam int RND_SHIFT = 33;

    localparam logic signed [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

    // width of a gradient term with the identity folded in
    function automatic int lin_width(int coef_w);
        return ((coef_w > 29) ? coef_w : 29) + 1;
    endfunction

    // accumulator width: largest term exponent plus growth and sign
    function automatic int acc_width(int coord_w, int coef_w);
        int m;
        int l;
        m = coef_w + 2 * coord_w - 1;
        l = lin_width(coef_w) + coord_w + 17;
        if (l > m) begin
            m = l;
        end
        if (coef_w + 32 > m) begin
            m = coef_w + 32;
        end
        m = m + 3;
        return (m < 66) ? 66 : m;
    endfunction

endpackage

`default_nettype wire

@@ rtl/qpw_point_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface qpw_point_if #(
    parameter int COORD_WIDTH = qpw_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;

    modport source (output valid, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

`default_nettype wire

@@ rtl/qpw_warp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface qpw_warp_if;
    import qpw_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] warped_x;
    logic signed [OUT_W-1:0] warped_y;
    logic                    clipped;

    modport source (output valid, output warped_x, output warped_y, output clipped,
                    input ready);
    modport sink   (input valid, input warped_x, input warped_y, input clipped,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/quadratic_point_warp_2d.sv @@
// Quadratic point warp.
// Points enter on i_point (valid/ready, pos_x/pos_y signed with 4 fraction
// bits) and leave on o_warp (warped_x/warped_y in Q16.16 plus a clipped flag
// set when either coordinate saturated). Shape coefficients are written
// through i_cfg_wr_en/i_cfg_index/i_cfg_data; the user must write them only
// while no request is in flight, and the block itself does not enforce this.
// Throughput: one point per cycle while the receiver does not stall. Five
// register stages: squares, coefficient products, partial sums, final sum,
// round and saturate. Each stage is a register with its own valid bit.
// A stage advances whenever it is empty or the one after it advances, so
// bubbles close up; i_point.ready falls only when all five stages hold data
// and the receiver is stalling. A stalled result holds in the output stage.
// Reset empties the pipeline and sets every coefficient to zero, i.e. the
// identity warp.
`timescale 1ns / 1ps
`default_nettype none
`include "quadratic_point_warp_2d_macros.svh"

module quadratic_point_warp_2d #(
    parameter int COORD_WIDTH = qpw_pkg::COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = qpw_pkg::COEF_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [qpw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [qpw_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    qpw_point_if.sink                        i_point,
    qpw_warp_if.source                       o_warp
);
    import qpw_pkg::*;

    localparam int LIN_W  = lin_width(COEF_WIDTH);
    localparam int STAGES = 5;
    localparam int SQ_W   = 2 * COORD_WIDTH;

    logic [STAGES-1:0] r_valid, n_valid, w_en;
    t_stage_en         w_stage_en;

    logic signed [COORD_WIDTH-1:0]   r_px, r_py;
    logic signed [2*COORD_WIDTH-1:0] n_sq_x, n_sq_y, n_xy;
    logic signed [2*COORD_WIDTH-1:0] r_sq_x, r_sq_y, r_xy;

    logic signed [COEF_WIDTH-1:0] w_u, w_v;
    logic signed [LIN_W-1:0]      w_lin_ux, w_lin_uy, w_lin_vx, w_lin_vy;
    logic signed [COEF_WIDTH-1:0] w_uxx, w_uxy, w_uyy, w_vxx, w_vxy, w_vyy;

    logic signed [OUT_W-1:0] w_res_x, w_res_y;
    logic                    w_clip_x, w_clip_y;

    // stage enables, output side first
    assign w_en[4] = ~r_valid[4] | o_warp.ready;
    assign w_en[3] = ~r_valid[3] | w_en[4];
    assign w_en[2] = ~r_valid[2] | w_en[3];
    assign w_en[1] = ~r_valid[1] | w_en[2];
    assign w_en[0] = ~r_valid[0] | w_en[1];

    assign w_stage_en = '{s1: w_en[1], s2: w_en[2], s3: w_en[3], s4: w_en[4]};

    assign n_valid[0] = w_en[0] ? i_point.valid : r_valid[0];
    assign n_valid[1] = w_en[1] ? r_valid[0]    : r_valid[1];
    assign n_valid[2] = w_en[2] ? r_valid[1]    : r_valid[2];
    assign n_valid[3] = w_en[3] ? r_valid[2]    : r_valid[3];
    assign n_valid[4] = w_en[4] ? r_valid[3]    : r_valid[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // stage 0: coordinate squares and cross product
    assign n_sq_x = SQ_W'(i_point.pos_x) * SQ_W'(i_point.pos_x);
    assign n_sq_y = SQ_W'(i_point.pos_y) * SQ_W'(i_point.pos_y);
    assign n_xy   = SQ_W'(i_point.pos_x) * SQ_W'(i_point.pos_y);

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_px   <= i_point.pos_x;
            r_py   <= i_point.pos_y;
            r_sq_x <= n_sq_x;
            r_sq_y <= n_sq_y;
            r_xy   <= n_xy;
        end
    end

    qpw_cfg #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_wr_en),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_u        (w_u),
        .o_v        (w_v),
        .o_lin_ux   (w_lin_ux),
        .o_lin_uy   (w_lin_uy),
        .o_lin_vx   (w_lin_vx),
        .o_lin_vy   (w_lin_vy),
        .o_uxx      (w_uxx),
        .o_uxy      (w_uxy),
        .o_uyy      (w_uyy),
        .o_vxx      (w_vxx),
        .o_vxy      (w_vxy),
        .o_vyy      (w_vyy)
    );

    qpw_axis #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_axis_x (
        .i_clk    (i_clk),
        .i_en     (w_stage_en),
        .i_px     (r_px),
        .i_py     (r_py),
        .i_sq_x   (r_sq_x),
        .i_sq_y   (r_sq_y),
        .i_xy     (r_xy),
        .i_cxx    (w_uxx),
        .i_cxy    (w_uxy),
        .i_cyy    (w_uyy),
        .i_lin_x  (w_lin_ux),
        .i_lin_y  (w_lin_uy),
        .i_off    (w_u),
        .o_result (w_res_x),
        .o_clip   (w_clip_x)
    );

    qpw_axis #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_axis_y (
        .i_clk    (i_clk),
        .i_en     (w_stage_en),
        .i_px     (r_px),
        .i_py     (r_py),
        .i_sq_x   (r_sq_x),
        .i_sq_y   (r_sq_y),
        .i_xy     (r_xy),
        .i_cxx    (w_vxx),
        .i_cxy    (w_vxy),
        .i_cyy    (w_vyy),
        .i_lin_x  (w_lin_vx),
        .i_lin_y  (w_lin_vy),
        .i_off    (w_v),
        .o_result (w_res_y),
        .o_clip   (w_clip_y)
    );

    assign i_point.ready   = w_en[0];
    assign o_warp.valid    = r_valid[4];
    assign o_warp.warped_x = w_res_x;
    assign o_warp.warped_y = w_res_y;
    assign o_warp.clipped  = w_clip_x | w_clip_y;

    `QPW_ASSERT_NEXT(a_accept_loads_s0, i_clk, i_rst_n, i_point.valid && i_point.ready, r_valid[0], "accepted request missing from stage 0")
    `QPW_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, !i_point.ready, &r_valid, "input stalled while a stage was empty")
    `QPW_ASSERT_NOW(a_clip_is_saturated, i_clk, i_rst_n, o_warp.valid && o_warp.clipped, o_warp.warped_x == SAT_MAX || o_warp.warped_x == SAT_MIN || o_warp.warped_y == SAT_MAX || o_warp.warped_y == SAT_MIN, "clipped flag without a saturated coordinate")

endmodule

`default_nettype wire

@@ rtl/qpw_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module qpw_cfg #(
    parameter int COEF_WIDTH = qpw_pkg::COEF_WIDTH_DEF
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_wr_en,
    input  logic [qpw_pkg::CFG_IDX_W-1:0]                    i_wr_index,
    input  logic [qpw_pkg::CFG_DATA_W-1:0]                   i_wr_data,
    output logic signed [COEF_WIDTH-1:0]                     o_u,
    output logic signed [COEF_WIDTH-1:0]                     o_v,
    output logic signed [qpw_pkg::lin_width(COEF_WIDTH)-1:0] o_lin_ux,
    output logic signed [qpw_pkg::lin_width(COEF_WIDTH)-1:0] o_lin_uy,
    output logic signed [qpw_pkg::lin_width(COEF_WIDTH)-1:0] o_lin_vx,
    output logic signed [qpw_pkg::lin_width(COEF_WIDTH)-1:0] o_lin_vy,
    output logic signed [COEF_WIDTH-1:0]                     o_uxx,
    output logic signed [COEF_WIDTH-1:0]                     o_uxy,
    output logic signed [COEF_WIDTH-1:0]                     o_uyy,
    output logic signed [COEF_WIDTH-1:0]                     o_vxx,
    output logic signed [COEF_WIDTH-1:0]                     o_vxy,
    output logic signed [COEF_WIDTH-1:0]                     o_vyy
);
    import qpw_pkg::*;

    localparam int LIN_W = lin_width(COEF_WIDTH);
    localparam logic signed [LIN_W-1:0] LIN_ONE = LIN_W'(ONE_Q28);

    logic signed [COEF_WIDTH-1:0] w_lo;
    logic signed [COEF_WIDTH-1:0] w_hi;

    logic signed [COEF_WIDTH-1:0] r_u, r_v;
    logic signed [LIN_W-1:0]      r_lin_ux, r_lin_uy, r_lin_vx, r_lin_vy;
    logic signed [COEF_WIDTH-1:0] r_uxx, r_uxy, r_uyy, r_vxx, r_vxy, r_vyy;

    // only the low COEF_WIDTH bits of each half count
    assign w_lo = i_wr_data[COEF_WIDTH-1:0];
    assign w_hi = i_wr_data[HALF_W+COEF_WIDTH-1:HALF_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u      <= '0;
            r_v      <= '0;
            r_lin_ux <= LIN_ONE;
            r_lin_uy <= '0;
            r_lin_vx <= '0;
            r_lin_vy <= LIN_ONE;
            r_uxx    <= '0;
            r_uxy    <= '0;
            r_uyy    <= '0;
            r_vxx    <= '0;
            r_vxy    <= '0;
            r_vyy    <= '0;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                REG_DISP: begin
                    r_u <= w_lo;
                    r_v <= w_hi;
                end
                REG_GRAD_U: begin
                    r_lin_ux <= LIN_W'(w_lo) + LIN_ONE;
                    r_lin_uy <= LIN_W'(w_hi);
                end
                REG_GRAD_V: begin
                    r_lin_vx <= LIN_W'(w_lo);
                    r_lin_vy <= LIN_W'(w_hi) + LIN_ONE;
                end
                REG_CURV_1: begin
                    r_uxx <= w_lo;
                    r_uxy <= w_hi;
                end
                REG_CURV_2: begin
                    r_uyy <= w_lo;
                    r_vxx <= w_hi;
                end
                REG_CURV_3: begin
                    r_vxy <= w_lo;
                    r_vyy <= w_hi;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_u      = r_u;
    assign o_v      = r_v;
    assign o_lin_ux = r_lin_ux;
    assign o_lin_uy = r_lin_uy;
    assign o_lin_vx = r_lin_vx;
    assign o_lin_vy = r_lin_vy;
    assign o_uxx    = r_uxx;
    assign o_uxy    = r_uxy;
    assign o_uyy    = r_uyy;
    assign o_vxx    = r_vxx;
    assign o_vxy    = r_vxy;
    assign o_vyy    = r_vyy;

endmodule

`default_nettype wire

@@ rtl/qpw_axis.sv @@
`timescale 1ns / 1ps
`default_nettype none

module qpw_axis #(
    parameter int COORD_WIDTH = qpw_pkg::COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = qpw_pkg::COEF_WIDTH_DEF
) (
    input  logic                                             i_clk,
    input  qpw_pkg::t_stage_en                               i_en,
    input  logic signed [COORD_WIDTH-1:0]                    i_px,
    input  logic signed [COORD_WIDTH-1:0]                    i_py,
    input  logic signed [2*COORD_WIDTH-1:0]                  i_sq_x,
    input  logic signed [2*COORD_WIDTH-1:0]                  i_sq_y,
    input  logic signed [2*COORD_WIDTH-1:0]                  i_xy,
    input  logic signed [COEF_WIDTH-1:0]                     i_cxx,
    input  logic signed [COEF_WIDTH-1:0]                     i_cxy,
    input  logic signed [COEF_WIDTH-1:0]                     i_cyy,
    input  logic signed [qpw_pkg::lin_width(COEF_WIDTH)-1:0] i_lin_x,
    input  logic signed [qpw_pkg::lin_width(COEF_WIDTH)-1:0] i_lin_y,
    input  logic signed [COEF_WIDTH-1:0]                     i_off,
    output logic signed [qpw_pkg::OUT_W-1:0]                 o_result,
    output logic                                             o_clip
);
    import qpw_pkg::*;

    localparam int LIN_W = lin_width(COEF_WIDTH);
    localparam int ACC_W = acc_width(COORD_WIDTH, COEF_WIDTH);
    localparam int HI_W  = COEF_WIDTH + COORD_WIDTH;
    localparam int LO_W  = HI_W + 1;
    localparam int LP_W  = LIN_W + COORD_WIDTH;
    localparam int RND_W = ACC_W - RND_SHIFT;

    // second-order products split into signed high and unsigned low halves
    logic signed [COORD_WIDTH-1:0] w_sqx_hi, w_xy_hi, w_sqy_hi;
    logic signed [COORD_WIDTH:0]   w_sqx_lo, w_xy_lo, w_sqy_lo;

    logic signed [HI_W-1:0] n_pxx_hi, n_pxy_hi, n_pyy_hi;
    logic signed [LO_W-1:0] n_pxx_lo, n_pxy_lo, n_pyy_lo;
    logic signed [LP_W-1:0] n_plx, n_ply;
    logic signed [HI_W-1:0] r_pxx_hi, r_pxy_hi, r_pyy_hi;
    logic signed [LO_W-1:0] r_pxx_lo, r_pxy_lo, r_pyy_lo;
    logic signed [LP_W-1:0] r_plx, r_ply;

    logic signed [ACC_W-1:0] w_off;
    logic signed [ACC_W-1:0] n_sum_a, n_sum_b, n_sum_c;
    logic signed [ACC_W-1:0] r_sum_a, r_sum_b, r_sum_c;
    logic signed [ACC_W-1:0] n_sum, r_sum;

    logic        [RND_W-1:0]   w_rnd;
    logic                      w_fits;
    logic signed [OUT_W-1:0]   n_result, r_result;
    logic                      n_clip, r_clip;

    // stage 1: coefficient products
    assign w_sqx_hi = i_sq_x[2*COORD_WIDTH-1:COORD_WIDTH];
    assign w_xy_hi  = i_xy[2*COORD_WIDTH-1:COORD_WIDTH];
    assign w_sqy_hi = i_sq_y[2*COORD_WIDTH-1:COORD_WIDTH];
    assign w_sqx_lo = {1'b0, i_sq_x[COORD_WIDTH-1:0]};
    assign w_xy_lo  = {1'b0, i_xy[COORD_WIDTH-1:0]};
    assign w_sqy_lo = {1'b0, i_sq_y[COORD_WIDTH-1:0]};

    assign n_pxx_hi = HI_W'(i_cxx) * HI_W'(w_sqx_hi);
    assign n_pxx_lo = LO_W'(i_cxx) * LO_W'(w_sqx_lo);
    assign n_pxy_hi = HI_W'(i_cxy) * HI_W'(w_xy_hi);
    assign n_pxy_lo = LO_W'(i_cxy) * LO_W'(w_xy_lo);
    assign n_pyy_hi = HI_W'(i_cyy) * HI_W'(w_sqy_hi);
    assign n_pyy_lo = LO_W'(i_cyy) * LO_W'(w_sqy_lo);
    assign n_plx    = LP_W'(i_lin_x) * LP_W'(i_px);
    assign n_ply    = LP_W'(i_lin_y) * LP_W'(i_py);

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_pxx_hi <= n_pxx_hi;
            r_pxx_lo <= n_pxx_lo;
            r_pxy_hi <= n_pxy_hi;
            r_pxy_lo <= n_pxy_lo;
            r_pyy_hi <= n_pyy_hi;
            r_pyy_lo <= n_pyy_lo;
            r_plx    <= n_plx;
            r_ply    <= n_ply;
        end
    end

    // stage 2: three partial sums at 2^-49; offset carries the rounding half
    assign w_off = {(ACC_W-RND_SHIFT)'(i_off), 1'b1, (RND_SHIFT-1)'(0)};

    assign n_sum_a = (ACC_W'(r_pxx_hi) <<< COORD_WIDTH) + ACC_W'(r_pxx_lo) + w_off;
    assign n_sum_b = (ACC_W'(r_pxy_hi) <<< (COORD_WIDTH + 1)) + (ACC_W'(r_pxy_lo) <<< 1)
                   + (ACC_W'(r_plx) <<< LIN_SHIFT);
    assign n_sum_c = (ACC_W'(r_pyy_hi) <<< COORD_WIDTH) + ACC_W'(r_pyy_lo)
                   + (ACC_W'(r_ply) <<< LIN_SHIFT);

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
            r_sum_c <= n_sum_c;
        end
    end

    // stage 3: full sum
    assign n_sum = r_sum_a + r_sum_b + r_sum_c;

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_sum <= n_sum;
        end
    end

    // stage 4: drop to Q16.16 and saturate
    assign w_rnd    = r_sum[ACC_W-1:RND_SHIFT];
    assign w_fits   = (&w_rnd[RND_W-1:OUT_W-1]) | ~(|w_rnd[RND_W-1:OUT_W-1]);
    assign n_result = w_fits ? w_rnd[OUT_W-1:0] : (r_sum[ACC_W-1] ? SAT_MIN : SAT_MAX);
    assign n_clip   = ~w_fits;

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_result <= n_result;
            r_clip   <= n_clip;
        end
    end

    assign o_result = r_result;
    assign o_clip   = r_clip;

endmodule

`default_nettype wire

@@ tb/quadratic_point_warp_2d_tb.sv @@
`timescale 1ns / 1ps

module quadratic_point_warp_2d_tb;
    import qpw_pkg::*;

    localparam int ACC_W = 96;
    localparam int PHASES = 14;
    localparam int POINTS_PER_PHASE = 120;

    // indexes past the register map; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_HI = 3'd7;

    typedef struct packed {
        logic signed [OUT_W-1:0] wx;
        logic signed [OUT_W-1:0] wy;
        logic                    clip;
    } t_warp_result;

    typedef enum logic { ROW_POINT, ROW_WRITE } t_row_kind;

    typedef struct {
        t_row_kind                      kind;
        logic [CFG_IDX_W-1:0]           idx;
        logic [CFG_DATA_W-1:0]          data;
        logic signed [COORD_WIDTH_DEF-1:0] px;
        logic signed [COORD_WIDTH_DEF-1:0] py;
        bit                             typed;
        t_warp_result                   want;
    } t_stim_row;

    typedef enum { HALF_ZERO, HALF_FULL, HALF_NARROW, HALF_EDGE, HALF_MAX, HALF_MIN } t_half_style;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    qpw_point_if #(.COORD_WIDTH(COORD_WIDTH_DEF)) point_if ();
    qpw_warp_if warp_if ();

    quadratic_point_warp_2d dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_point     (point_if),
        .o_warp      (warp_if)
    );

    logic [CFG_DATA_W-1:0] shape_regs [REG_DISP:REG_CURV_3];
    t_warp_result          pending_warps [$];
    t_warp_result          got_want;
    int                    warp_errors = 0;
    int                    burst_left = 0;
    int                    gap_max = 3;
    logic [15:0]           ready_pattern = 16'hFFFF;
    logic [3:0]            pattern_pos = '0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic signed [HALF_W-1:0] coef_half(input logic [CFG_DATA_W-1:0] r,
                                                           input bit upper);
        logic [HALF_W-1:0] h;
        h = upper ? r[63:32] : r[31:0];
        h = h << (HALF_W - COEF_WIDTH_DEF);
        return $signed(h) >>> (HALF_W - COEF_WIDTH_DEF);
    endfunction

    // exact sum at 2^-49, round half up to Q16.16, saturate
    function automatic logic signed [OUT_W-1:0] warp_axis_q16(
        input logic signed [HALF_W-1:0] c_sq_x,
        input logic signed [HALF_W-1:0] c_cross,
        input logic signed [HALF_W-1:0] c_sq_y,
        input logic signed [HALF_W:0]   lin_x,
        input logic signed [HALF_W:0]   lin_y,
        input logic signed [HALF_W-1:0] offset,
        input logic signed [COORD_WIDTH_DEF-1:0] px,
        input logic signed [COORD_WIDTH_DEF-1:0] py,
        output logic sat);
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] wx;
        logic signed [ACC_W-1:0] wy;
        wx = ACC_W'(px);
        wy = ACC_W'(py);
        acc = ACC_W'(c_sq_x) * wx * wx + ((ACC_W'(c_cross) * wx * wy) <<< 1)
            + ACC_W'(c_sq_y) * wy * wy
            + ((ACC_W'(lin_x) * wx) <<< LIN_SHIFT) + ((ACC_W'(lin_y) * wy) <<< LIN_SHIFT)
            + (ACC_W'(offset) <<< RND_SHIFT) + (ACC_W'(1) <<< (RND_SHIFT - 1));
        acc = acc >>> RND_SHIFT;
        sat = 1'b0;
        if (acc > ACC_W'(SAT_MAX)) begin
            sat = 1'b1;
            return SAT_MAX;
        end
        if (acc < ACC_W'(SAT_MIN)) begin
            sat = 1'b1;
            return SAT_MIN;
        end
        return acc[OUT_W-1:0];
    endfunction

    function automatic t_warp_result predict_warp(input logic signed [COORD_WIDTH_DEF-1:0] px,
                                                  input logic signed [COORD_WIDTH_DEF-1:0] py);
        t_warp_result r;
        logic signed [HALF_W:0] lin_ux;
        logic signed [HALF_W:0] lin_uy;
        logic signed [HALF_W:0] lin_vx;
        logic signed [HALF_W:0] lin_vy;
        logic sat_x;
        logic sat_y;
        lin_ux = (HALF_W+1)'(coef_half(shape_regs[REG_GRAD_U], 1'b0));
        lin_ux = lin_ux + (HALF_W+1)'(ONE_Q28);
        lin_uy = (HALF_W+1)'(coef_half(shape_regs[REG_GRAD_U], 1'b1));
        lin_vx = (HALF_W+1)'(coef_half(shape_regs[REG_GRAD_V], 1'b0));
        lin_vy = (HALF_W+1)'(coef_half(shape_regs[REG_GRAD_V], 1'b1));
        lin_vy = lin_vy + (HALF_W+1)'(ONE_Q28);
        r.wx = warp_axis_q16(coef_half(shape_regs[REG_CURV_1], 1'b0),
                             coef_half(shape_regs[REG_CURV_1], 1'b1),
                             coef_half(shape_regs[REG_CURV_2], 1'b0),
                             lin_ux, lin_uy, coef_half(shape_regs[REG_DISP], 1'b0),
                             px, py, sat_x);
        r.wy = warp_axis_q16(coef_half(shape_regs[REG_CURV_2], 1'b1),
                             coef_half(shape_regs[REG_CURV_3], 1'b0),
                             coef_half(shape_regs[REG_CURV_3], 1'b1),
                             lin_vx, lin_vy, coef_half(shape_regs[REG_DISP], 1'b1),
                             px, py, sat_y);
        r.clip = sat_x | sat_y;
        return r;
    endfunction

    function automatic t_stim_row point_row(input logic signed [COORD_WIDTH_DEF-1:0] px,
                                            input logic signed [COORD_WIDTH_DEF-1:0] py);
        t_stim_row row;
        row = '{kind: ROW_POINT, idx: REG_DISP, data: '0, px: px, py: py, typed: 1'b0,
                want: '0};
        return row;
    endfunction

    function automatic t_stim_row point_row_exp(input logic signed [COORD_WIDTH_DEF-1:0] px,
                                                input logic signed [COORD_WIDTH_DEF-1:0] py,
                                                input logic signed [OUT_W-1:0] wx,
                                                input logic signed [OUT_W-1:0] wy,
                                                input logic clip);
        t_stim_row row;
        row = point_row(px, py);
        row.typed = 1'b1;
        row.want = '{wx: wx, wy: wy, clip: clip};
        return row;
    endfunction

    function automatic t_stim_row write_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        t_stim_row row;
        row = point_row('0, '0);
        row.kind = ROW_WRITE;
        row.idx = idx;
        row.data = data;
        return row;
    endfunction

    function automatic logic [HALF_W-1:0] rand_half(input t_half_style style);
        logic [HALF_W-1:0] v;
        int w;
        case (style)
            HALF_ZERO: v = '0;
            HALF_FULL: v = $urandom;
            HALF_NARROW: begin
                w = $urandom_range(1, 31);
                v = $urandom >> (32 - w);
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
            HALF_EDGE: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0001;
                endcase
            end
            HALF_MAX: v = 32'h7FFF_FFFF;
            default: v = 32'h8000_0000;
        endcase
        return v;
    endfunction

    function automatic t_half_style pick_style();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return HALF_ZERO;
        if (k <= 2) return HALF_FULL;
        if (k <= 8) return HALF_NARROW;
        return HALF_EDGE;
    endfunction

    function automatic logic signed [COORD_WIDTH_DEF-1:0] rand_coord();
        logic signed [COORD_WIDTH_DEF-1:0] c;
        logic [31:0] r;
        int k;
        k = $urandom_range(0, 9);
        r = $urandom;
        if (k == 0) begin
            case ($urandom_range(0, 3))
                0: c = 16'sh7FFF;
                1: c = 16'sh8000;
                2: c = '0;
                default: c = -16'sd1;
            endcase
        end else if (k <= 4) begin
            c = COORD_WIDTH_DEF'($urandom_range(0, 2047));
            c = c - 16'sd1024;
        end else begin
            c = r[15:0];
        end
        return c;
    endfunction

    task automatic write_shape_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        if (idx >= REG_DISP && idx <= REG_CURV_3) begin
            shape_regs[idx] = data;
        end
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_point(input logic signed [COORD_WIDTH_DEF-1:0] px,
                              input logic signed [COORD_WIDTH_DEF-1:0] py,
                              input bit typed,
                              input t_warp_result want);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap != 0) begin
                point_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        point_if.valid <= 1'b1;
        point_if.pos_x <= px;
        point_if.pos_y <= py;
        do @(posedge i_clk); while (point_if.ready !== 1'b1);
        pending_warps.push_back(typed ? want : predict_warp(px, py));
        burst_left--;
    endtask

    task automatic drain_warps();
        point_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_warps.size() != 0) @(posedge i_clk);
    endtask

    // result checker and receiver stall pattern
    initial begin
        warp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && warp_if.valid === 1'b1 && warp_if.ready === 1'b1) begin
                if (pending_warps.size() == 0) begin
                    $error("warp request with nothing expected: x=%0d y=%0d",
                           warp_if.warped_x, warp_if.warped_y);
                    warp_errors++;
                end else begin
                    got_want = pending_warps.pop_front();
                    if (warp_if.warped_x !== got_want.wx) begin
                        $error("warped_x: expected %0d, got %0d", got_want.wx, warp_if.warped_x);
                        warp_errors++;
                    end
                    if (warp_if.warped_y !== got_want.wy) begin
                        $error("warped_y: expected %0d, got %0d", got_want.wy, warp_if.warped_y);
                        warp_errors++;
                    end
                    if (warp_if.clipped !== got_want.clip) begin
                        $error("clipped: expected %0d, got %0d", got_want.clip, warp_if.clipped);
                        warp_errors++;
                    end
                end
            end
            warp_if.ready <= ready_pattern[pattern_pos];
            pattern_pos <= pattern_pos + 4'd1;
        end
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        t_stim_row directed_rows [$];
        t_half_style style;
        bit in_flight;

        i_rst_n        <= 1'b0;
        i_cfg_wr_en    <= 1'b0;
        i_cfg_index    <= REG_DISP;
        i_cfg_data     <= '0;
        point_if.valid <= 1'b0;
        point_if.pos_x <= '0;
        point_if.pos_y <= '0;
        for (int r = REG_DISP; r <= REG_CURV_3; r++) begin
            shape_regs[r] = '0;
        end
        in_flight = 1'b0;

        directed_rows = '{
            // identity warp out of reset: Q12.4 -> Q16.16 is a shift by 12
            point_row_exp(16'sd0, 16'sd0, 32'sd0, 32'sd0, 1'b0),
            point_row_exp(16'sh7FFF, 16'sh8000, 32'sd134213632, -32'sd134217728, 1'b0),
            point_row_exp(16'sh8000, 16'sh7FFF, -32'sd134217728, 32'sd134213632, 1'b0),
            point_row_exp(16'sd1, -16'sd1, 32'sd4096, -32'sd4096, 1'b0),
            point_row_exp(16'sd16, 16'sd16, 32'sd65536, 32'sd65536, 1'b0),
            // unmapped indexes leave the warp untouched
            write_row(IDX_UNMAPPED_LO, '1),
            write_row(IDX_UNMAPPED_HI, '1),
            point_row_exp(16'sh7FFF, 16'sh7FFF, 32'sd134213632, 32'sd134213632, 1'b0),
            // offsets at the rails: exact fit at origin, saturation away from it
            write_row(REG_DISP, {SAT_MIN, SAT_MAX}),
            write_row(REG_GRAD_U, {32'h0, 32'h7FFF_FFFF}),
            point_row_exp(16'sd0, 16'sd0, SAT_MAX, SAT_MIN, 1'b0),
            point_row_exp(16'sh7FFF, 16'sh8000, SAT_MAX, SAT_MIN, 1'b1),
            point_row(16'sd16, 16'sd0),
            point_row(16'sh8000, 16'sd0),
            // curvature and gradient extremes
            write_row(REG_CURV_1, {32'h7FFF_FFFF, 32'h8000_0000}),
            write_row(REG_CURV_2, {32'h8000_0000, 32'h7FFF_FFFF}),
            write_row(REG_CURV_3, {32'h7FFF_FFFF, 32'h7FFF_FFFF}),
            write_row(REG_GRAD_V, {32'h8000_0000, 32'h8000_0000}),
            point_row(16'sh7FFF, 16'sh7FFF),
            point_row(16'sh8000, 16'sh8000),
            point_row(16'sh8000, 16'sh7FFF),
            point_row(16'sd5, -16'sd3),
            // exact half LSB from the cross term: rounds toward +inf
            write_row(REG_DISP, '0),
            write_row(REG_GRAD_U, '0),
            write_row(REG_GRAD_V, '0),
            write_row(REG_CURV_1, {32'd2, 32'd0}),
            write_row(REG_CURV_2, '0),
            write_row(REG_CURV_3, '0),
            point_row_exp(16'sh8000, 16'sh8000, -32'sd134217727, -32'sd134217728, 1'b0),
            write_row(REG_CURV_1, {32'hFFFF_FFFE, 32'd0}),
            point_row_exp(16'sh8000, 16'sh8000, -32'sd134217728, -32'sd134217728, 1'b0)
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                if (in_flight) begin
                    drain_warps();
                end
                write_shape_reg(directed_rows[i].idx, directed_rows[i].data);
                in_flight = 1'b0;
            end else begin
                send_point(directed_rows[i].px, directed_rows[i].py,
                           directed_rows[i].typed, directed_rows[i].want);
                in_flight = 1'b1;
            end
        end
        drain_warps();

        for (int ph = 0; ph < PHASES; ph++) begin
            for (int r = REG_DISP; r <= REG_CURV_3; r++) begin
                if (ph == 0) begin
                    style = HALF_MAX;
                end else if (ph == 1) begin
                    style = HALF_MIN;
                end else begin
                    style = pick_style();
                end
                write_shape_reg(CFG_IDX_W'(r),
                                {rand_half(ph < 2 ? style : pick_style()), rand_half(style)});
            end
            if ($urandom_range(0, 3) == 0) begin
                write_shape_reg($urandom_range(0, 1) == 1 ? IDX_UNMAPPED_HI : IDX_UNMAPPED_LO,
                                {$urandom, $urandom});
            end
            ready_pattern = (ph % 3 == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
            gap_max = (ph % 4 == 1) ? 0 : $urandom_range(1, 8);
            repeat (POINTS_PER_PHASE) send_point(rand_coord(), rand_coord(), 1'b0, '0);
            drain_warps();
        end

        repeat (12) @(posedge i_clk);
        if (warp_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
